### design/idl_pkg.sv
package idl_pkg;

  // Field widths of the command and result transfers.
  localparam int ModeBits     = 3;
  localparam int PositionBits = 7;
  localparam int WordBits     = 32;
  localparam int CountBits    = 7;

  // Command codes carried in the mode field.
  typedef enum logic [ModeBits-1:0] {
    MODE_APPEND    = 3'd0,
    MODE_PREPEND   = 3'd1,
    MODE_INSERT    = 3'd2,
    MODE_POP_BACK  = 3'd3,
    MODE_POP_FRONT = 3'd4,
    MODE_REMOVE    = 3'd5,
    MODE_GET       = 3'd6,
    MODE_SET       = 3'd7
  } mode_e;

  // Operation class seen by the cell array.
  typedef enum logic [1:0] {
    OP_PUT,
    OP_TAKE,
    OP_READ,
    OP_WRITE
  } op_e;

  // Controller states.
  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

  // One command transfer.
  typedef struct packed {
    logic [ModeBits-1:0]     mode;
    logic [PositionBits-1:0] position;
    logic [WordBits-1:0]     value_in;
  } in_t;

  // One result transfer.
  typedef struct packed {
    logic                 ok;
    logic [WordBits-1:0]  value_out;
    logic [CountBits-1:0] count;
  } out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic execute;
  } ctrl_cmd_t;

endpackage

### design/indexed_deque_list_unit.sv
// Sequence: an accepted command is latched in the command register, then executed in the
// ST_EXEC state, which writes the result register; no new command is accepted until then.
// Each execute step shifts the cells from the target position up for insertions and
// removals; execution waits while the previous result is still unclaimed.
// Reset: synchronous, active high; clears the entry count and the handshake state.
module indexed_deque_list_unit #(
  parameter int CAPACITY   = 64,
  parameter int VALUE_BITS = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  idl_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output idl_pkg::out_t out_data
);

  idl_pkg::ctrl_cmd_t cmd;

  // Sequencing of the command and result transfers.
  idl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // Cell chain, entry count and result register.
  idl_datapath #(
    .CAPACITY   (CAPACITY),
    .VALUE_BITS (VALUE_BITS)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .in_data  (in_data),
    .out_data (out_data)
  );

endmodule

### design/idl_ctrl.sv
module idl_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output idl_pkg::ctrl_cmd_t cmd
);

  idl_pkg::state_e state;
  idl_pkg::state_e state_next;
  logic            out_free;

  // The result register may be refilled once its current transfer completes.
  assign out_free = !out_valid || out_ready;

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      idl_pkg::ST_IDLE: begin
        if (in_valid) state_next = idl_pkg::ST_EXEC;
      end
      idl_pkg::ST_EXEC: begin
        if (out_free) state_next = idl_pkg::ST_IDLE;
      end
      default: state_next = idl_pkg::ST_IDLE;
    endcase
  end

  // Output logic.
  always_comb begin
    in_ready    = 1'b0;
    cmd.load    = 1'b0;
    cmd.execute = 1'b0;
    unique case (state)
      idl_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      idl_pkg::ST_EXEC: begin
        cmd.execute = out_free;
      end
      default: ;
    endcase
  end

  // State and result-valid registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= idl_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.execute) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_no_accept_in_exec: assert property (@(posedge clk) disable iff (rst)
    state == idl_pkg::ST_EXEC |-> !in_ready)
    else $error("command accepted while a command is executing");

  a_load_then_exec: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> state == idl_pkg::ST_EXEC)
    else $error("accepted command did not enter execution");

  a_exec_gives_result: assert property (@(posedge clk) disable iff (rst)
    cmd.execute |=> out_valid && state == idl_pkg::ST_IDLE)
    else $error("executed command produced no result");

endmodule

### design/idl_datapath.sv
module idl_datapath #(
  parameter int CAPACITY   = 64,
  parameter int VALUE_BITS = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  idl_pkg::ctrl_cmd_t cmd,
  input  idl_pkg::in_t       in_data,
  output idl_pkg::out_t      out_data
);

  localparam int CntW  = $clog2(CAPACITY + 1);
  localparam int PosW  = (CntW > idl_pkg::PositionBits) ? CntW : idl_pkg::PositionBits;
  localparam int WideW = (VALUE_BITS > idl_pkg::WordBits) ? VALUE_BITS : idl_pkg::WordBits;

  logic [CntW-1:0]       used_count;
  logic [CntW-1:0]       used_next;
  logic [VALUE_BITS-1:0] cell_q [CAPACITY];

  // Latched command, decoded against the count at accept time.
  idl_pkg::op_e          op;
  idl_pkg::op_e          op_next;
  logic                  cmd_ok;
  logic                  cmd_ok_next;
  logic [PosW-1:0]       target;
  logic [PosW-1:0]       target_next;
  logic [VALUE_BITS-1:0] word;

  logic [PosW-1:0]       pos_w;
  logic [PosW-1:0]       used_w;
  logic                  full;
  logic [WideW-1:0]      in_wide;
  logic [VALUE_BITS-1:0] got;
  logic [WideW-1:0]      got_wide;
  idl_pkg::out_t         result;

  assign pos_w   = PosW'(in_data.position);
  assign used_w  = PosW'(used_count);
  assign full    = (used_count == CntW'(CAPACITY));
  assign in_wide = WideW'(in_data.value_in);

  // Decode the command into an operation class, a target position and a verdict.
  always_comb begin
    op_next     = idl_pkg::OP_READ;
    cmd_ok_next = 1'b0;
    target_next = pos_w;
    unique case (idl_pkg::mode_e'(in_data.mode))
      idl_pkg::MODE_APPEND: begin
        op_next     = idl_pkg::OP_PUT;
        cmd_ok_next = !full;
        target_next = used_w;
      end
      idl_pkg::MODE_PREPEND: begin
        op_next     = idl_pkg::OP_PUT;
        cmd_ok_next = !full;
        target_next = '0;
      end
      idl_pkg::MODE_INSERT: begin
        op_next     = idl_pkg::OP_PUT;
        cmd_ok_next = !full && (pos_w <= used_w);
      end
      idl_pkg::MODE_POP_BACK: begin
        op_next     = idl_pkg::OP_TAKE;
        cmd_ok_next = (used_count != '0);
        target_next = used_w - PosW'(1);
      end
      idl_pkg::MODE_POP_FRONT: begin
        op_next     = idl_pkg::OP_TAKE;
        cmd_ok_next = (used_count != '0);
        target_next = '0;
      end
      idl_pkg::MODE_REMOVE: begin
        op_next     = idl_pkg::OP_TAKE;
        cmd_ok_next = (pos_w < used_w);
      end
      idl_pkg::MODE_GET: begin
        op_next     = idl_pkg::OP_READ;
        cmd_ok_next = (pos_w < used_w);
      end
      idl_pkg::MODE_SET: begin
        op_next     = idl_pkg::OP_WRITE;
        cmd_ok_next = (pos_w < used_w);
      end
      default: ;
    endcase
  end

  // Command register, loaded when a command transfer completes.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op     <= op_next;
      cmd_ok <= cmd_ok_next;
      target <= target_next;
      word   <= in_wide[VALUE_BITS-1:0];
    end
  end

  // Each cell takes a new word, its lower neighbour or its upper neighbour.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    always_ff @(posedge clk) begin
      if (cmd.execute && cmd_ok) begin
        case (op)
          idl_pkg::OP_PUT: begin
            if (target == PosW'(i)) begin
              cell_q[i] <= word;
            end else if (target < PosW'(i)) begin
              cell_q[i] <= cell_q[(i > 0) ? i - 1 : 0];
            end
          end
          idl_pkg::OP_TAKE: begin
            if ((target <= PosW'(i)) && (i < CAPACITY - 1)) begin
              cell_q[i] <= cell_q[(i < CAPACITY - 1) ? i + 1 : i];
            end
          end
          idl_pkg::OP_WRITE: begin
            if (target == PosW'(i)) cell_q[i] <= word;
          end
          default: ;
        endcase
      end
    end
  end

  // Read port: every cell drives the bus when its position matches.
  always_comb begin
    got = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (target == PosW'(i)) got = got | cell_q[i];
    end
  end

  assign got_wide = WideW'(got);

  // Count after the command.
  always_comb begin
    used_next = used_count;
    if (cmd_ok) begin
      case (op)
        idl_pkg::OP_PUT:  used_next = used_count + CntW'(1);
        idl_pkg::OP_TAKE: used_next = used_count - CntW'(1);
        default: ;
      endcase
    end
  end

  // Result word.
  always_comb begin
    result.ok        = cmd_ok;
    result.value_out = '0;
    if (cmd_ok && (op == idl_pkg::OP_TAKE || op == idl_pkg::OP_READ)) begin
      result.value_out = got_wide[idl_pkg::WordBits-1:0];
    end
    result.count = idl_pkg::CountBits'(used_next);
  end

  // Entry count and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      used_count <= '0;
    end else if (cmd.execute) begin
      used_count <= used_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.execute) out_data <= result;
  end

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    used_count <= CntW'(CAPACITY))
    else $error("entry count exceeds the capacity");

  a_count_moves_by_one: assert property (@(posedge clk) disable iff (rst)
    !cmd.execute |=> used_count == $past(used_count))
    else $error("entry count changed without an executed command");

endmodule
